/* design/cst_pkg.sv */
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, constants and the arctangent table for the CORDIC
// sine / cosine / tangent unit.
// ----------------------------------------------------------------------------
package cst_pkg;

	// iteration count and its counter width
	localparam int ITERATIONS = 14;
	localparam int ITER_W     = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

	// field widths
	localparam int ACTION_W = 2;
	localparam int ANGLE_W  = 18;
	localparam int VALUE_W  = 30;

	// internal widths
	localparam int FRAC_BITS = 14;
	localparam int RES_W     = 20;                // residual angle
	localparam int XY_W      = 18;                // rotation vector
	localparam int DIVD_W    = XY_W + FRAC_BITS;  // dividend magnitude
	localparam int DCNT_W    = $clog2(DIVD_W);
	localparam int GAIN_W    = 15;

	// fixed-point constants
	localparam logic signed [XY_W-1:0]   Q_ONE     = XY_W'(16384);
	localparam logic signed [RES_W-1:0]  Q_PI      = RES_W'(51472);
	localparam logic signed [RES_W-1:0]  Q_HALF_PI = RES_W'(25736);
	localparam logic signed [GAIN_W-1:0] GAIN      = GAIN_W'(9949);

	// action codes
	localparam logic [ACTION_W-1:0] ACT_SIN = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_COS = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TAN = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_POST,
		ST_MUL,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} state_t;

	// arctangent table, Q14 radians
	function automatic logic signed [RES_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
		logic signed [RES_W-1:0] v;
		case (idx)
			4'd0:    v = RES_W'(12867);
			4'd1:    v = RES_W'(7596);
			4'd2:    v = RES_W'(4013);
			4'd3:    v = RES_W'(2037);
			4'd4:    v = RES_W'(1022);
			4'd5:    v = RES_W'(511);
			4'd6:    v = RES_W'(255);
			4'd7:    v = RES_W'(127);
			4'd8:    v = RES_W'(63);
			4'd9:    v = RES_W'(31);
			4'd10:   v = RES_W'(15);
			4'd11:   v = RES_W'(7);
			4'd12:   v = RES_W'(3);
			4'd13:   v = RES_W'(1);
			default: v = RES_W'(0);
		endcase
		return v;
	endfunction

endpackage

/* design/cst_if.sv */
// ----------------------------------------------------------------------------
// cst_if
// Valid/ready channels for the CORDIC unit: command beats in, result beats out.
// ----------------------------------------------------------------------------
interface cst_in_if import cst_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic signed [ANGLE_W-1:0]  angle;

	modport source (output valid, output action, output angle, input ready);
	modport sink   (input valid, input action, input angle, output ready);
endinterface

interface cst_out_if import cst_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  value;
	logic                       div_by_zero;

	modport source (output valid, output value, output div_by_zero, input ready);
	modport sink   (input valid, input value, input div_by_zero, output ready);
endinterface

/* design/cordic_sin_cos_tan_q14.sv */
// ----------------------------------------------------------------------------
// cordic_sin_cos_tan_q14
// Q14 sine, cosine and tangent by rotation-mode CORDIC on one shared
// shift/add unit, with a gain multiply and a restoring divider for tangent.
// ----------------------------------------------------------------------------
// Steps: sine/cosine run 14 rotations and the gain multiply; tangent runs 14
//   rotations, then 32 divider steps and a sign fix if x is not zero.
// Throughput: one command at a time; the next command is taken the cycle
//   after the result moves into the output register, even if it is not yet
//   taken downstream.
// Reset: arst_n clears the sequencer and the output valid at once.
// ----------------------------------------------------------------------------
module cordic_sin_cos_tan_q14 import cst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cst_in_if.sink      cmd,
	cst_out_if.source   rsp
);

	// sequencer
	state_t state_q, state_d;

	// operand and working registers
	logic [ACTION_W-1:0]        act_q;
	logic                       flip_q;
	logic signed [RES_W-1:0]    ang_q;
	logic signed [XY_W-1:0]     x_q, y_q;
	logic [ITER_W-1:0]          cnt_q;

	// divider
	logic [XY_W-1:0]            rem_q;
	logic [DIVD_W-1:0]          quo_q;
	logic [XY_W-1:0]            dsr_q;
	logic                       neg_q;
	logic [DCNT_W-1:0]          dcnt_q;

	// result staging and output register
	logic signed [VALUE_W-1:0]  res_q;
	logic                       flag_q;
	logic                       out_valid_q;
	logic signed [VALUE_W-1:0]  out_value_q;
	logic                       out_flag_q;

	// control outputs of the sequencer
	logic take_cmd;
	logic load_out;
	logic out_free;

	assign out_free = !out_valid_q || rsp.ready;

	// ------------------------------------------------------------------
	// Fold the incoming angle once by pi
	// ------------------------------------------------------------------
	logic signed [RES_W-1:0] ang_ext;
	logic signed [RES_W-1:0] ang_fold;
	logic                    fold_hi, fold_lo;

	assign ang_ext = RES_W'(cmd.angle);
	assign fold_hi = ang_ext > Q_HALF_PI;
	assign fold_lo = ang_ext < -Q_HALF_PI;

	always_comb begin
		if (fold_hi) begin
			ang_fold = ang_ext - Q_PI;
		end else if (fold_lo) begin
			ang_fold = ang_ext + Q_PI;
		end else begin
			ang_fold = ang_ext;
		end
	end

	// ------------------------------------------------------------------
	// Shared rotation unit: one barrel shift pair and three adders
	// ------------------------------------------------------------------
	logic signed [XY_W-1:0]  xs, ys;
	logic signed [XY_W-1:0]  x_nx, y_nx;
	logic signed [RES_W-1:0] ang_nx;
	logic                    rot_neg;

	assign xs      = x_q >>> cnt_q;
	assign ys      = y_q >>> cnt_q;
	// a residual of exactly zero takes the negative direction
	assign rot_neg = !(ang_q > 0);

	always_comb begin
		if (rot_neg) begin
			x_nx   = x_q + ys;
			y_nx   = y_q - xs;
			ang_nx = ang_q + atan_lut(cnt_q);
		end else begin
			x_nx   = x_q - ys;
			y_nx   = y_q + xs;
			ang_nx = ang_q - atan_lut(cnt_q);
		end
	end

	// ------------------------------------------------------------------
	// Gain multiply: src * 9949, arithmetic shift by 14, undo the fold
	// ------------------------------------------------------------------
	localparam int PROD_W = XY_W + GAIN_W;

	logic signed [XY_W-1:0]   mul_src;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [PROD_W-1:0] prod_fix;

	assign mul_src  = (act_q == ACT_SIN) ? y_q : x_q;
	assign prod     = PROD_W'(mul_src) * PROD_W'(GAIN);
	assign prod_sh  = prod >>> FRAC_BITS;
	assign prod_fix = flip_q ? -prod_sh : prod_sh;

	// ------------------------------------------------------------------
	// Restoring divider step: |y| << 14 over |x|, one quotient bit a cycle
	// ------------------------------------------------------------------
	logic [XY_W-1:0] abs_x, abs_y;
	logic [XY_W:0]   trial;
	logic [XY_W:0]   trial_sub;
	logic            trial_ok;

	assign abs_x     = x_q[XY_W-1] ? XY_W'(-x_q) : XY_W'(x_q);
	assign abs_y     = y_q[XY_W-1] ? XY_W'(-y_q) : XY_W'(y_q);
	assign trial     = {rem_q, quo_q[DIVD_W-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign trial_ok  = trial >= {1'b0, dsr_q};

	logic [DIVD_W-1:0] quo_sgn;
	assign quo_sgn = neg_q ? -quo_q : quo_q;

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) state_d = ST_ROT;
			end
			ST_ROT: begin
				if (cnt_q == ITER_W'(ITERATIONS - 1)) state_d = ST_POST;
			end
			ST_POST: begin
				if (act_q == ACT_SIN || act_q == ACT_COS) begin
					state_d = ST_MUL;
				end else if (act_q == ACT_TAN && x_q != '0) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MUL: state_d = ST_DONE;
			ST_DIV: begin
				if (dcnt_q == DCNT_W'(DIVD_W - 1)) state_d = ST_FIX;
			end
			ST_FIX: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs
	// ------------------------------------------------------------------
	always_comb begin
		take_cmd = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: take_cmd = 1'b1;
			ST_DONE: load_out = out_free;
			default: begin
				take_cmd = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	assign cmd.ready = take_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// latch the command beat and seed the vector
				if (cmd.valid) begin
					act_q  <= cmd.action;
					flip_q <= fold_hi || fold_lo;
					ang_q  <= ang_fold;
					x_q    <= Q_ONE;
					y_q    <= '0;
					cnt_q  <= '0;
				end
			end
			ST_ROT: begin
				x_q   <= x_nx;
				y_q   <= y_nx;
				ang_q <= ang_nx;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_POST: begin
				// prepare the divider; zero divisor and unused codes finish here
				rem_q  <= '0;
				quo_q  <= DIVD_W'(abs_y) << FRAC_BITS;
				dsr_q  <= abs_x;
				neg_q  <= x_q[XY_W-1] ^ y_q[XY_W-1];
				dcnt_q <= '0;
				res_q  <= '0;
				flag_q <= (act_q == ACT_TAN) && (x_q == '0);
			end
			ST_MUL: begin
				res_q <= prod_fix[VALUE_W-1:0];
			end
			ST_DIV: begin
				if (trial_ok) begin
					rem_q <= trial_sub[XY_W-1:0];
					quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[XY_W-1:0];
					quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 1'b1;
			end
			ST_FIX: begin
				// apply the quotient sign: truncation toward zero
				res_q <= quo_sgn[VALUE_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register: hold the result beat until taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= res_q;
			out_flag_q  <= flag_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.value       = out_value_q;
	assign rsp.div_by_zero = out_flag_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.div_by_zero |-> rsp.value == '0)
		else $error("div_by_zero beat with non-zero value");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> state_q == ST_ROT && cnt_q == '0)
		else $error("command beat did not start the rotation");

	a_div_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> dsr_q != '0 && act_q == ACT_TAN)
		else $error("divider running with zero divisor or wrong action");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || rsp.ready)
		else $error("output register overwritten while held");

endmodule

/* dv/cordic_check.sv */
// ----------------------------------------------------------------------------
// cordic_check
// Watches the command and result channels of the CORDIC unit, works out the
// expected result of every accepted command and compares each result beat
// with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module cordic_check import cst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cst_in_if    cmd,
	cst_out_if   rsp,
	output int   mismatches,
	output int   pending
);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      div_by_zero;
	} trig_result_t;

	localparam longint ONE_Q14     = 16384;
	localparam longint PI_Q14      = 51472;
	localparam longint HALF_PI_Q14 = 25736;
	localparam longint GAIN_Q14    = 9949;
	localparam longint ATAN_Q14 [14] = '{
		12867, 7596, 4013, 2037, 1022, 511, 255, 127, 63, 31, 15, 7, 3, 1
	};

	trig_result_t awaited_results [$];

	function automatic trig_result_t cordic_predict(input logic [ACTION_W-1:0] act,
	                                                input logic signed [ANGLE_W-1:0] ang);
		longint       resid;
		longint       x;
		longint       y;
		longint       xs;
		longint       ys;
		longint       v;
		logic         flip;
		logic         zero_div;
		trig_result_t r;
		resid    = longint'(ang);
		flip     = 1'b0;
		zero_div = 1'b0;
		x        = ONE_Q14;
		y        = 0;
		v        = 0;
		// fold once by pi into the half circle around zero
		if (resid > HALF_PI_Q14) begin
			resid = resid - PI_Q14;
			flip  = 1'b1;
		end else if (resid < -HALF_PI_Q14) begin
			resid = resid + PI_Q14;
			flip  = 1'b1;
		end
		for (int i = 0; i < ITERATIONS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			// a residual of exactly zero turns the negative way
			if (resid > 0) begin
				x     = x - ys;
				y     = y + xs;
				resid = resid - ATAN_Q14[i];
			end else begin
				x     = x + ys;
				y     = y - xs;
				resid = resid + ATAN_Q14[i];
			end
		end
		case (act)
			ACT_SIN: begin
				v = (y * GAIN_Q14) >>> FRAC_BITS;
				if (flip)
					v = -v;
			end
			ACT_COS: begin
				v = (x * GAIN_Q14) >>> FRAC_BITS;
				if (flip)
					v = -v;
			end
			ACT_TAN: begin
				if (x == 0)
					zero_div = 1'b1;
				else
					v = (y * ONE_Q14) / x;
			end
			default: v = 0;
		endcase
		r.value       = v[VALUE_W-1:0];
		r.div_by_zero = zero_div;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int           n_bad;
		trig_result_t want;
		if (!arst_n) begin
			mismatches <= 0;
			pending    <= 0;
		end else begin
			n_bad = 0;
			if (cmd.valid && cmd.ready)
				awaited_results.push_back(cordic_predict(cmd.action, cmd.angle));
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result beat: value %0d, div_by_zero %0b",
					       rsp.value, rsp.div_by_zero);
					n_bad++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp.value !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, rsp.value);
						n_bad++;
					end
					if (rsp.div_by_zero !== want.div_by_zero) begin
						$error("div_by_zero: expected %0b, got %0b",
						       want.div_by_zero, rsp.div_by_zero);
						n_bad++;
					end
				end
			end
			mismatches <= mismatches + n_bad;
			pending    <= awaited_results.size();
		end
	end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives sine, cosine, tangent and unused commands into the CORDIC unit:
// a directed set of fold boundaries and range extremes, then random angles
// with random gaps and stalls on both channels and one long result hold-off.
// The checker alongside does the comparing; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb import cst_pkg::*;;

	// spare action code, answers with zero
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

	localparam int DIRECTED_N     = 24;
	localparam int RANDOM_N       = 450;
	localparam int CALM_N         = 60;    // final beats with no idling at all
	localparam int HOLD_AFTER     = 100;   // commands sent before the long hold-off
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 80;    // extra wait once no result is pending
	localparam int WATCHDOG_LIMIT = 1500;

	// fold boundaries, the nominal range ends and the field extremes
	localparam logic [ACTION_W-1:0] DIR_ACT [DIRECTED_N] = '{
		ACT_SIN, ACT_COS, ACT_TAN, ACT_NONE,
		ACT_SIN, ACT_COS, ACT_TAN, ACT_TAN,
		ACT_SIN, ACT_COS, ACT_TAN,
		ACT_SIN, ACT_COS, ACT_TAN,
		ACT_SIN, ACT_COS, ACT_TAN,
		ACT_SIN, ACT_COS, ACT_TAN, ACT_NONE, ACT_NONE,
		ACT_SIN, ACT_TAN
	};
	localparam int DIR_ANG [DIRECTED_N] = '{
		0, 0, 0, 0,
		25736, 25736, 25736, -25736,
		25737, -25737, 25737,
		51472, -51472, 51472,
		77208, -77208, 77208,
		131071, -131072, -131072, 131071, -131072,
		-1, 1
	};

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   quiet_cycles;
	int   n_sent;
	logic calm;
	logic held;

	cst_in_if  cmd_if ();
	cst_out_if rsp_if ();

	cordic_sin_cos_tan_q14 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	cordic_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_if),
		.rsp        (rsp_if),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold valid high with the new payload and wait for the beat to go.
	// Valid is left high so back-to-back beats need no second assignment.
	task automatic offer_command(input logic [ACTION_W-1:0] act,
	                             input logic signed [ANGLE_W-1:0] ang);
		cmd_if.valid  <= 1'b1;
		cmd_if.action <= act;
		cmd_if.angle  <= ang;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		n_sent++;
	endtask

	// Drop valid for a random burst now and then, never once the run is calm.
	task automatic maybe_pause();
		if (!calm && $urandom_range(0, 4) == 0) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 13))
				@(posedge clk);
		end
	endtask

	// Command side: reset, directed beats, random beats, then drain and verdict.
	initial begin : stimulus
		int                        ang_int;
		int                        pick;
		logic [ACTION_W-1:0]       act;
		calm          = 1'b0;
		n_sent        = 0;
		arst_n        <= 1'b0;
		cmd_if.valid  <= 1'b0;
		cmd_if.action <= ACT_SIN;
		cmd_if.angle  <= '0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIRECTED_N; k++) begin
			maybe_pause();
			offer_command(DIR_ACT[k], ANGLE_W'(DIR_ANG[k]));
		end

		for (int k = 0; k < RANDOM_N; k++) begin
			if (k >= RANDOM_N - CALM_N)
				calm = 1'b1;
			// the unused code turns up now and then, the three real ones evenly
			pick = $urandom_range(0, 9);
			if (pick < 3)
				act = ACT_SIN;
			else if (pick < 6)
				act = ACT_COS;
			else if (pick < 9)
				act = ACT_TAN;
			else
				act = ACT_NONE;
			// mostly the nominal range, some hugging a fold, some anywhere in the field
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				ang_int = int'($urandom_range(0, 154416)) - 77208;
			end else if (pick < 9) begin
				ang_int = ($urandom_range(0, 1) != 0) ? 25736 : 51472;
				if ($urandom_range(0, 1) != 0)
					ang_int = -ang_int;
				ang_int = ang_int + int'($urandom_range(0, 16)) - 8;
			end else begin
				ang_int = int'($urandom_range(0, 262143)) - 131072;
			end
			maybe_pause();
			offer_command(act, ANGLE_W'(ang_int));
		end
		cmd_if.valid <= 1'b0;

		// let the checker see the last beat before looking at what is still owed
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Result side: random stall bursts, one long hold-off to back the unit up
	// into its command port, and ready held high through the calm tail.
	initial begin : drain
		held = 1'b0;
		rsp_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (calm) begin
				rsp_if.ready <= 1'b1;
				@(posedge clk);
			end else if (!held && n_sent >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 13))
					@(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				repeat ($urandom_range(1, 20))
					@(posedge clk);
			end
		end
	end

	// Watchdog: count cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule

/* files.f */
design/cst_pkg.sv
design/cst_if.sv
design/cordic_sin_cos_tan_q14.sv
dv/cordic_check.sv
dv/tb.sv
